// File: hw/rtl/oqkr_pkg.sv
// Package for the ordered queue with keyed remove.
// Holds the action codes, the fixed field widths and the control struct
// that the top level hands to every cell. No dependencies.
package oqkr_pkg;

  // Fixed widths of the channel fields.
  localparam int ACTION_W = 2;
  localparam int HANDLE_W = 16;
  localparam int KEY_W    = 16;
  localparam int COUNT_W  = 5;

  // Action codes carried by the input channel.
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_DELETE = 2'd3
  } action_t;

  // Operation broadcast to the whole row of cells.
  typedef struct packed {
    logic                en;
    action_t             action;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key_id;
  } oqkr_ctrl_t;

endpackage

// File: hw/rtl/oqkr_if.sv
// Channel interfaces of the ordered queue: operation input and result output.
// Both use a valid/ready handshake. Depends on oqkr_pkg.
interface oqkr_in_if import oqkr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [HANDLE_W-1:0] handle;
  logic [KEY_W-1:0]    key_id;

  modport source (output valid, output action, output handle, output key_id, input ready);
  modport sink   (input valid, input action, input handle, input key_id, output ready);
endinterface

interface oqkr_out_if import oqkr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                found;
  logic [HANDLE_W-1:0] handle_out;
  logic [COUNT_W-1:0]  entry_count;
  logic                overflow;

  modport source (output valid, output found, output handle_out, output entry_count,
                  output overflow, input ready);
  modport sink   (input valid, input found, input handle_out, input entry_count,
                  input overflow, output ready);
endinterface

// File: hw/rtl/oqkr_cell.sv
// One entry slot of the ordered queue: stores a handle and an ID, compares
// them against the broadcast key and shifts toward the head. Depends on oqkr_pkg.
module oqkr_cell import oqkr_pkg::*; #(
  parameter int HW = 16
) (
  input  logic              clk,
  input  oqkr_ctrl_t        ctrl,
  input  logic              live,      // slot lies below the occupancy
  input  logic              tail,      // slot is the first free one
  input  logic [HW-1:0]     nb_handle, // stored handle of the next slot
  input  logic [KEY_W-1:0]  nb_id,     // stored ID of the next slot
  input  logic              hit_in,    // a slot nearer the head matched
  input  logic [HW-1:0]     hand_in,   // handle of that earlier match
  output logic              hit_out,
  output logic [HW-1:0]     hand_out,
  output logic [HW-1:0]     handle_r,
  output logic [KEY_W-1:0]  id_r
);

  logic match;
  logic do_shift;
  logic do_write;

  // Local compare; find matches on ID, the other actions on the handle.
  always_comb begin
    if (ctrl.action == ACT_FIND) begin
      match = live && (id_r == ctrl.key_id);
    end else begin
      match = live && (handle_r == ctrl.handle[HW-1:0]);
    end
  end

  // First-match chain: an earlier hit wins and passes through unchanged.
  assign hit_out  = hit_in | match;
  assign hand_out = hit_in ? hand_in : handle_r;

  // Pop shifts every slot; delete shifts the matching slot and all behind it.
  always_comb begin
    case (ctrl.action)
      ACT_PUSH: begin
        do_shift = 1'b0;
        do_write = tail;
      end
      ACT_POP: begin
        do_shift = 1'b1;
        do_write = 1'b0;
      end
      ACT_DELETE: begin
        do_shift = hit_in | match;
        do_write = 1'b0;
      end
      default: begin
        do_shift = 1'b0;
        do_write = 1'b0;
      end
    endcase
  end

  // Slot storage; contents beyond the occupancy are don't-care.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      if (do_write) begin
        handle_r <= ctrl.handle[HW-1:0];
        id_r     <= ctrl.key_id;
      end else if (do_shift) begin
        handle_r <= nb_handle;
        id_r     <= nb_id;
      end
    end
  end

endmodule

// File: hw/rtl/ordered_queue_with_keyed_remove_top.sv
// Top level of the ordered queue with keyed remove: a row of oqkr_cell slots,
// the occupancy counter and the result register. Depends on oqkr_pkg, oqkr_if.
//
// Usage: each transfer on in_chan carries one action (push, pop, find by ID,
// delete by handle) and produces exactly one result on out_chan, registered
// in the cycle after the transfer. The block takes one operation per cycle while
// the result side keeps up; in_chan.ready is low during reset and otherwise
// drops only while a result waits untaken. The whole operation completes in
// its transfer cycle: every slot compares against the key in parallel, the first
// match is picked by a ripple through the row of cells, and delete or pop
// closes the gap by each slot loading its neighbor. No clearing pass is
// needed after reset.
module ordered_queue_with_keyed_remove_top import oqkr_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  oqkr_in_if.sink     in_chan,
  oqkr_out_if.source  out_chan
);

  localparam int HW    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  oqkr_ctrl_t          ctrl;
  action_t             action;
  logic                accept;
  logic [OCC_W-1:0]    occ_r;
  logic [OCC_W-1:0]    occ_nxt;
  logic                full;
  logic                empty;

  logic [QUEUE_DEPTH-1:0]   live;
  logic [QUEUE_DEPTH-1:0]   tail;
  logic [QUEUE_DEPTH:0]     hit;
  logic [HW-1:0]            hand  [QUEUE_DEPTH+1];
  logic [HW-1:0]            s_hnd [QUEUE_DEPTH];
  logic [KEY_W-1:0]         s_id  [QUEUE_DEPTH];

  logic                out_valid_r;
  logic                found_r;
  logic                found_nxt;
  logic [HANDLE_W-1:0] hout_r;
  logic [HANDLE_W-1:0] hout_nxt;
  logic [COUNT_W-1:0]  count_r;
  logic                ovf_r;
  logic                ovf_nxt;

  // Input handshake: the result register frees up when it is taken.
  assign in_chan.ready = rst_n && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign action        = action_t'(in_chan.action);

  assign ctrl.en     = accept;
  assign ctrl.action = action;
  assign ctrl.handle = in_chan.handle;
  assign ctrl.key_id = in_chan.key_id;

  assign full  = (occ_r == OCC_W'(QUEUE_DEPTH));
  assign empty = (occ_r == '0);

  // Row of slots with the first-match chain running from the head.
  assign hit[0]  = 1'b0;
  assign hand[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [HW-1:0]    nb_h;
    logic [KEY_W-1:0] nb_k;

    assign live[i] = (occ_r > OCC_W'(i));
    assign tail[i] = (occ_r == OCC_W'(i));

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb_h = s_hnd[i];
      assign nb_k = s_id[i];
    end else begin : g_mid
      assign nb_h = s_hnd[i+1];
      assign nb_k = s_id[i+1];
    end

    oqkr_cell #(.HW(HW)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .live      (live[i]),
      .tail      (tail[i]),
      .nb_handle (nb_h),
      .nb_id     (nb_k),
      .hit_in    (hit[i]),
      .hand_in   (hand[i]),
      .hit_out   (hit[i+1]),
      .hand_out  (hand[i+1]),
      .handle_r  (s_hnd[i]),
      .id_r      (s_id[i])
    );
  end

  // Result fields and the next occupancy for the current action.
  always_comb begin
    found_nxt = 1'b0;
    hout_nxt  = '0;
    ovf_nxt   = 1'b0;
    occ_nxt   = occ_r;
    case (action)
      ACT_PUSH: begin
        if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          found_nxt = 1'b1;
          occ_nxt   = occ_r + OCC_W'(1);
        end
      end
      ACT_POP: begin
        if (!empty) begin
          found_nxt = 1'b1;
          hout_nxt  = HANDLE_W'(s_hnd[0]);
          occ_nxt   = occ_r - OCC_W'(1);
        end
      end
      ACT_FIND: begin
        if (hit[QUEUE_DEPTH]) begin
          found_nxt = 1'b1;
          hout_nxt  = HANDLE_W'(hand[QUEUE_DEPTH]);
        end
      end
      ACT_DELETE: begin
        if (hit[QUEUE_DEPTH]) begin
          found_nxt = 1'b1;
          occ_nxt   = occ_r - OCC_W'(1);
        end
      end
      default: begin
        found_nxt = 1'b0;
      end
    endcase
  end

  // Occupancy counter and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        occ_r       <= occ_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      found_r <= found_nxt;
      hout_r  <= hout_nxt;
      count_r <= COUNT_W'(occ_nxt);
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = found_r;
  assign out_chan.handle_out  = hout_r;
  assign out_chan.entry_count = count_r;
  assign out_chan.overflow    = ovf_r;

endmodule

// File: dv/ordered_queue_with_keyed_remove_top_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for ordered_queue_with_keyed_remove_top.
// Depends on oqkr_pkg, the oqkr_in_if and oqkr_out_if channel interfaces and the top level.
module ordered_queue_with_keyed_remove_top_test;
  import oqkr_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_ROWS    = 27;
  localparam int NUM_RANDOM  = 1500;

  // One result transfer, field by field.
  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] handle_out;
    logic [COUNT_W-1:0]  entry_count;
    logic                overflow;
  } queue_result_t;

  // One row of the directed table; fixed rows carry their result typed in.
  typedef struct packed {
    action_t             act;
    logic [HANDLE_W-1:0] handle;
    logic [KEY_W-1:0]    key_id;
    logic                fixed;
    queue_result_t       res;
  } op_row_t;

  logic clk;
  logic rst_n;

  oqkr_in_if  in_ch ();
  oqkr_out_if out_ch ();

  ordered_queue_with_keyed_remove_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .HANDLE_BITS(HANDLE_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  // Shadow copy of the queue contents, head first.
  logic [HANDLE_W-1:0] model_handles [$];
  logic [KEY_W-1:0]    model_ids [$];

  queue_result_t pending_results [$];
  queue_result_t typed_res;
  logic          typed_fixed;
  bit            idle_on;
  int            stall_left;
  int            error_count;
  op_row_t       op_table [NUM_ROWS];

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one operation to the shadow queue and returns its result.
  function automatic queue_result_t queue_model_apply(action_t act,
                                                      logic [HANDLE_W-1:0] h,
                                                      logic [KEY_W-1:0] id);
    queue_result_t r;
    int i;
    int pos;
    r = '0;
    pos = -1;
    case (act)
      ACT_PUSH: begin
        if (model_handles.size() < QUEUE_DEPTH) begin
          model_handles.push_back(h);
          model_ids.push_back(id);
          r.found = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
      ACT_POP: begin
        if (model_handles.size() > 0) begin
          r.handle_out = model_handles.pop_front();
          void'(model_ids.pop_front());
          r.found = 1'b1;
        end
      end
      ACT_FIND: begin
        for (i = 0; i < model_ids.size(); i++) begin
          if (pos < 0 && model_ids[i] == id) pos = i;
        end
        if (pos >= 0) begin
          r.handle_out = model_handles[pos];
          r.found = 1'b1;
        end
      end
      default: begin
        for (i = 0; i < model_handles.size(); i++) begin
          if (pos < 0 && model_handles[i] == h) pos = i;
        end
        if (pos >= 0) begin
          model_handles.delete(pos);
          model_ids.delete(pos);
          r.found = 1'b1;
        end
      end
    endcase
    r.entry_count = COUNT_W'(model_handles.size());
    return r;
  endfunction

  task automatic note_failure(string what, queue_result_t exp, queue_result_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s: expected found=%0b handle=%h count=%0d ovf=%0b",
               $realtime, what, exp.found, exp.handle_out, exp.entry_count, exp.overflow);
      $display("  got found=%0b handle=%h count=%0d ovf=%0b",
               got.found, got.handle_out, got.entry_count, got.overflow);
    end
  endtask

  // Monitor: check each result transfer, then predict each accepted operation.
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t exp;
    queue_result_t pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.found       = out_ch.found;
        got.handle_out  = out_ch.handle_out;
        got.entry_count = out_ch.entry_count;
        got.overflow    = out_ch.overflow;
        if (pending_results.size() == 0) begin
          note_failure("result with none outstanding", '0, got);
        end else begin
          exp = pending_results.pop_front();
          if (got.found !== exp.found || got.handle_out !== exp.handle_out ||
              got.entry_count !== exp.entry_count || got.overflow !== exp.overflow) begin
            note_failure("result mismatch", exp, got);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pred = queue_model_apply(action_t'(in_ch.action), in_ch.handle, in_ch.key_id);
        pending_results.push_back(typed_fixed ? typed_res : pred);
      end
    end
  end

  // Result side: random stall bursts while idling is on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(5) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(3);
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Drives one operation and holds it until the transfer completes.
  task automatic send_op(action_t act, logic [HANDLE_W-1:0] h, logic [KEY_W-1:0] id,
                         logic fixed, queue_result_t res);
    if (idle_on && $urandom_range(3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.handle = h;
    in_ch.key_id = id;
    typed_fixed  = fixed;
    typed_res    = res;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() > 0) @(negedge clk);
  endtask

  // Picks a handle, mostly from the live entries or a small pool for duplicates.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5 && model_handles.size() > 0)
      return model_handles[$urandom_range(model_handles.size() - 1)];
    else if (sel < 8)
      return HANDLE_W'($urandom_range(7));
    return HANDLE_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [KEY_W-1:0] pick_id();
    int sel;
    sel = $urandom_range(9);
    if (sel < 5 && model_ids.size() > 0)
      return model_ids[$urandom_range(model_ids.size() - 1)];
    else if (sel < 8)
      return KEY_W'($urandom_range(7));
    return KEY_W'($urandom_range(16'hFFFF));
  endfunction

  // Directed table: empty-queue misses, extremes, handle zero, duplicates,
  // filling to the top, a dropped push and removal from a full queue.
  initial begin
    op_table = '{
      '{ACT_POP,    16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 5'd0,  1'b0}},
      '{ACT_FIND,   16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 5'd0,  1'b0}},
      '{ACT_DELETE, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 5'd0,  1'b0}},
      '{ACT_PUSH,   16'h0000, 16'h0000, 1'b1, '{1'b1, 16'h0000, 5'd1,  1'b0}},
      '{ACT_PUSH,   16'hFFFF, 16'hFFFF, 1'b1, '{1'b1, 16'h0000, 5'd2,  1'b0}},
      '{ACT_FIND,   16'h0000, 16'hFFFF, 1'b1, '{1'b1, 16'hFFFF, 5'd2,  1'b0}},
      '{ACT_FIND,   16'hFFFF, 16'h0000, 1'b1, '{1'b1, 16'h0000, 5'd2,  1'b0}},
      '{ACT_PUSH,   16'h1234, 16'h0000, 1'b1, '{1'b1, 16'h0000, 5'd3,  1'b0}},
      '{ACT_DELETE, 16'h0000, 16'h0000, 1'b1, '{1'b1, 16'h0000, 5'd2,  1'b0}},
      '{ACT_FIND,   16'h0000, 16'h0000, 1'b1, '{1'b1, 16'h1234, 5'd2,  1'b0}},
      '{ACT_PUSH,   16'h5555, 16'hAAAA, 1'b0, '0},
      '{ACT_PUSH,   16'hAAAA, 16'h5555, 1'b0, '0},
      '{ACT_PUSH,   16'h0001, 16'hFFFF, 1'b0, '0},
      '{ACT_PUSH,   16'h8000, 16'h0001, 1'b0, '0},
      '{ACT_PUSH,   16'hFFFF, 16'h8000, 1'b0, '0},
      '{ACT_PUSH,   16'h00FF, 16'hFF00, 1'b0, '0},
      '{ACT_PUSH,   16'hFF00, 16'h00FF, 1'b0, '0},
      '{ACT_PUSH,   16'h0F0F, 16'hF0F0, 1'b0, '0},
      '{ACT_PUSH,   16'hF0F0, 16'h0F0F, 1'b0, '0},
      '{ACT_PUSH,   16'h3C3C, 16'hC3C3, 1'b0, '0},
      '{ACT_PUSH,   16'hC3C3, 16'h3C3C, 1'b0, '0},
      '{ACT_PUSH,   16'h7FFF, 16'h0000, 1'b0, '0},
      '{ACT_PUSH,   16'h0002, 16'hFFFE, 1'b0, '0},
      '{ACT_PUSH,   16'h1234, 16'h4321, 1'b0, '0},
      '{ACT_PUSH,   16'h9999, 16'h9999, 1'b1, '{1'b0, 16'h0000, 5'd16, 1'b1}},
      '{ACT_DELETE, 16'hFFFF, 16'h0000, 1'b0, '0},
      '{ACT_POP,    16'h0000, 16'h0000, 1'b0, '0}
    };
  end

  // Stimulus: reset, directed table, then random operations.
  initial begin
    int i;
    int r;
    int push_pct;
    action_t act;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_PUSH;
    in_ch.handle = '0;
    in_ch.key_id = '0;
    out_ch.ready = 1'b1;
    typed_fixed  = 1'b0;
    typed_res    = '0;
    idle_on      = 1'b0;
    stall_left   = 0;
    error_count  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    idle_on = 1'b1;

    for (i = 0; i < NUM_ROWS; i++) begin
      send_op(op_table[i].act, op_table[i].handle, op_table[i].key_id,
              op_table[i].fixed, op_table[i].res);
    end
    // Let everything drain before the random part starts.
    wait_drained();

    for (i = 0; i < NUM_RANDOM; i++) begin
      // Segments alternate between filling and draining; every third one runs
      // without idling, and the tail of the run has none at all.
      idle_on  = ((i / 100) % 3 != 2) && (i < NUM_RANDOM - 150);
      push_pct = ((i / 100) % 2 == 0) ? 60 : 30;
      if (i == NUM_RANDOM / 2) wait_drained();
      r = $urandom_range(99);
      if ($urandom_range(19) == 0) begin
        act = action_t'($urandom_range(3));
        send_op(act, HANDLE_W'($urandom_range(16'hFFFF)), KEY_W'($urandom_range(16'hFFFF)),
                1'b0, '0);
      end else if (r < push_pct) begin
        send_op(ACT_PUSH, pick_handle(), pick_id(), 1'b0, '0);
      end else begin
        r = $urandom_range(2);
        if (r == 0) act = ACT_POP;
        else if (r == 1) act = ACT_FIND;
        else act = ACT_DELETE;
        send_op(act, pick_handle(), pick_id(), 1'b0, '0);
      end
    end

    in_ch.valid = 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/oqkr_pkg.sv
hw/rtl/oqkr_if.sv
hw/rtl/oqkr_cell.sv
hw/rtl/ordered_queue_with_keyed_remove_top.sv
dv/ordered_queue_with_keyed_remove_top_test.sv
